[sv/issf_pkg.sv]
package issf_pkg;

  localparam logic [31:0] FRAME_MAGIC      = 32'h494D_5530;
  localparam logic [15:0] FRAME_VERSION_HW = 16'h0100;
  localparam logic [15:0] FRAME_BYTES      = 16'd70;
  localparam int unsigned FRAME_HALVES     = 35;
  localparam int unsigned HW_IDX_W         = $clog2(FRAME_HALVES);

  localparam logic [7:0] ACCEL_CTL_RESET = 8'd64;
  localparam logic [7:0] GYRO_CTL_RESET  = 8'd76;

  localparam logic signed [26:0] TEMP_SCALE  = 27'sd1000;
  localparam logic signed [26:0] TEMP_OFFSET = 27'sd25000;
  localparam logic signed [26:0] TEMP_BIAS   = 27'sd255;
  localparam logic [31:0]        GYRO_ROUND  = 32'd500;

  // Unsigned x / 1000 for any 32-bit x is (x * DIV1000_RECIP) >> DIV1000_SHIFT.
  localparam logic [28:0] DIV1000_RECIP = 29'h1062_4DD3;
  localparam int unsigned DIV1000_SHIFT = 38;

  typedef enum logic [0:0] {
    REG_ACCEL_CTL = 1'b0,
    REG_GYRO_CTL  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]      temperature_raw;
    logic [2:0][15:0] gyro_raw;
    logic [2:0][15:0] accel_raw;
    logic [63:0]      monotonic_time_ns;
    logic [63:0]      wall_time_ns;
  } sample_t;

  typedef struct packed {
    sample_t               raw;
    logic signed [26:0]    temp_p;
    logic [2:0]            gyro_neg;
    logic [2:0][31:0]      gyro_mag;
    logic [2:0][31:0]      accel_p;
  } prod_t;

  typedef struct packed {
    logic [31:0]      seq;
    sample_t          raw;
    logic [31:0]      temp_m;
    logic [2:0][31:0] gyro_m;
    logic [2:0][31:0] accel_m;
  } frame_t;

  function automatic logic [13:0] accel_lsb_weight(input logic [7:0] ctl);
    logic [13:0] s;
    unique case (ctl[3:2])
      2'd0: s = 14'd1197;
      2'd1: s = 14'd9577;
      2'd2: s = 14'd2394;
      2'd3: s = 14'd4788;
      default: s = 14'd1197;
    endcase
    return s;
  endfunction

  function automatic logic [16:0] gyro_lsb_weight(input logic [7:0] ctl);
    logic [16:0] s;
    if (ctl[1]) begin
      s = 17'd4375;
    end else begin
      unique case (ctl[3:2])
        2'd0: s = 17'd8750;
        2'd1: s = 17'd17500;
        2'd2: s = 17'd35000;
        2'd3: s = 17'd70000;
        default: s = 17'd8750;
      endcase
    end
    return s;
  endfunction

endpackage

[sv/issf_if.sv]
interface issf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature_raw;
  logic [15:0] gyro_x_raw;
  logic [15:0] gyro_y_raw;
  logic [15:0] gyro_z_raw;
  logic [15:0] accel_x_raw;
  logic [15:0] accel_y_raw;
  logic [15:0] accel_z_raw;
  logic [63:0] monotonic_time_ns;
  logic [63:0] wall_time_ns;

  modport source (
    output valid, temperature_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
           accel_x_raw, accel_y_raw, accel_z_raw, monotonic_time_ns, wall_time_ns,
    input  ready
  );
  modport sink (
    input  valid, temperature_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
           accel_x_raw, accel_y_raw, accel_z_raw, monotonic_time_ns, wall_time_ns,
    output ready
  );
endinterface

interface issf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_halfword;
  logic        frame_last;

  modport source (output valid, frame_halfword, frame_last, input ready);
  modport sink (input valid, frame_halfword, frame_last, output ready);
endinterface

[sv/issf_frame_ser.sv]
module issf_frame_ser
  import issf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              frm_valid,
  input  frame_t            frm_in,
  output logic              frm_ready,
  issf_out_if.source        out_frm
);

  frame_t                frm_r;
  logic                  frm_valid_r;
  logic [HW_IDX_W-1:0]   idx_r;
  logic [HW_IDX_W-1:0]   idx_nxt;
  logic                  out_valid_r;
  logic [15:0]           out_hw_r;
  logic                  out_last_r;
  logic [15:0]           hw_sel;
  logic                  out_load;
  logic                  last_hw;

  assign out_load  = frm_valid_r && (!out_valid_r || out_frm.ready);
  assign last_hw   = (idx_r == HW_IDX_W'(FRAME_HALVES - 1));
  // A new frame may enter while the last halfword of the current one moves out.
  assign frm_ready = !frm_valid_r || (out_load && last_hw);

  always_comb begin
    unique case (idx_r)
      6'd0:  hw_sel = FRAME_MAGIC[31:16];
      6'd1:  hw_sel = FRAME_MAGIC[15:0];
      6'd2:  hw_sel = FRAME_VERSION_HW;
      6'd3:  hw_sel = FRAME_BYTES;
      6'd4:  hw_sel = frm_r.seq[31:16];
      6'd5:  hw_sel = frm_r.seq[15:0];
      6'd6:  hw_sel = frm_r.raw.monotonic_time_ns[63:48];
      6'd7:  hw_sel = frm_r.raw.monotonic_time_ns[47:32];
      6'd8:  hw_sel = frm_r.raw.monotonic_time_ns[31:16];
      6'd9:  hw_sel = frm_r.raw.monotonic_time_ns[15:0];
      6'd10: hw_sel = frm_r.raw.wall_time_ns[63:48];
      6'd11: hw_sel = frm_r.raw.wall_time_ns[47:32];
      6'd12: hw_sel = frm_r.raw.wall_time_ns[31:16];
      6'd13: hw_sel = frm_r.raw.wall_time_ns[15:0];
      6'd14: hw_sel = frm_r.raw.temperature_raw;
      6'd15: hw_sel = frm_r.raw.gyro_raw[0];
      6'd16: hw_sel = frm_r.raw.gyro_raw[1];
      6'd17: hw_sel = frm_r.raw.gyro_raw[2];
      6'd18: hw_sel = frm_r.raw.accel_raw[0];
      6'd19: hw_sel = frm_r.raw.accel_raw[1];
      6'd20: hw_sel = frm_r.raw.accel_raw[2];
      6'd21: hw_sel = frm_r.temp_m[31:16];
      6'd22: hw_sel = frm_r.temp_m[15:0];
      6'd23: hw_sel = frm_r.gyro_m[0][31:16];
      6'd24: hw_sel = frm_r.gyro_m[0][15:0];
      6'd25: hw_sel = frm_r.gyro_m[1][31:16];
      6'd26: hw_sel = frm_r.gyro_m[1][15:0];
      6'd27: hw_sel = frm_r.gyro_m[2][31:16];
      6'd28: hw_sel = frm_r.gyro_m[2][15:0];
      6'd29: hw_sel = frm_r.accel_m[0][31:16];
      6'd30: hw_sel = frm_r.accel_m[0][15:0];
      6'd31: hw_sel = frm_r.accel_m[1][31:16];
      6'd32: hw_sel = frm_r.accel_m[1][15:0];
      6'd33: hw_sel = frm_r.accel_m[2][31:16];
      6'd34: hw_sel = frm_r.accel_m[2][15:0];
      default: hw_sel = '0;
    endcase
  end

  always_comb begin
    if (frm_ready) begin
      idx_nxt = '0;
    end else if (out_load) begin
      idx_nxt = idx_r + HW_IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (frm_ready) begin
        frm_valid_r <= frm_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_frm.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      frm_r <= frm_in;
    end
    if (out_load) begin
      out_hw_r   <= hw_sel;
      out_last_r <= last_hw;
    end
  end

  assign out_frm.valid          = out_valid_r;
  assign out_frm.frame_halfword = out_hw_r;
  assign out_frm.frame_last     = out_last_r;

endmodule

[sv/imu_sample_scale_and_frame_unit.sv]
// IMU sample scaling and framing unit.
//
// Raw samples arrive as beats on in_smp (valid/ready); each one yields a
// 70-byte big-endian frame that leaves on out_frm as 35 halfword beats, the
// earlier byte in the upper half, with frame_last set on the final beat.
// The accelerometer and gyro control bytes sit behind a small APB port at
// byte addresses 0 and 4; they should only be rewritten while no frame is
// in flight.
// After its sample beat is taken, the sample passes through the input
// register, the product register and the frame register, and the first
// halfword of its frame then becomes valid in the output register. The
// sample rate is set by the serialiser, which moves one halfword per cycle
// when the receiver does not stall. Up to two further samples are taken
// and converted while a frame is streaming out.
// Reset clears all valid flags and the frame sequence number, and restores
// the control bytes to 64 and 76. When the receiver holds ready low the
// current halfword stays on out_frm and back-pressure reaches in_smp once
// the pipeline registers are full.
module imu_sample_scale_and_frame_unit
  import issf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  issf_in_if.sink     in_smp,
  issf_out_if.source  out_frm,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  accel_ctl_r;
  logic [7:0]  gyro_ctl_r;
  logic [31:0] seq_r;
  logic        s1_valid_r;
  sample_t     s1_r;
  logic        s2_valid_r;
  prod_t       s2_r;
  prod_t       prod_nxt;
  frame_t      frame_nxt;
  sample_t     in_sample;
  logic        frm_ready;
  logic        s1_take;
  logic        s2_take;
  logic        cfg_wr;
  reg_idx_t    reg_sel;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_ACCEL_CTL: prdata = {24'd0, accel_ctl_r};
      REG_GYRO_CTL:  prdata = {24'd0, gyro_ctl_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_ctl_r <= ACCEL_CTL_RESET;
      gyro_ctl_r  <= GYRO_CTL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ACCEL_CTL: accel_ctl_r <= pwdata[7:0];
        REG_GYRO_CTL:  gyro_ctl_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign s2_take      = !s2_valid_r || frm_ready;
  assign s1_take      = !s1_valid_r || s2_take;
  assign in_smp.ready = s1_take;

  assign in_sample.temperature_raw   = in_smp.temperature_raw;
  assign in_sample.gyro_raw          = {in_smp.gyro_z_raw, in_smp.gyro_y_raw, in_smp.gyro_x_raw};
  assign in_sample.accel_raw         = {in_smp.accel_z_raw, in_smp.accel_y_raw,
                                        in_smp.accel_x_raw};
  assign in_sample.monotonic_time_ns = in_smp.monotonic_time_ns;
  assign in_sample.wall_time_ns      = in_smp.wall_time_ns;

  // Stage one: products. Gyro values are taken as magnitude plus sign so that
  // rounding half away from zero becomes a plain add before the divide.
  always_comb begin
    logic [16:0]        gscale;
    logic signed [31:0] ascale;
    logic [15:0]        gabs;
    gscale            = gyro_lsb_weight(gyro_ctl_r);
    ascale            = $signed({18'd0, accel_lsb_weight(accel_ctl_r)});
    prod_nxt.raw      = s1_r;
    prod_nxt.temp_p   = $signed(s1_r.temperature_raw) * TEMP_SCALE;
    prod_nxt.gyro_neg = '0;
    prod_nxt.gyro_mag = '0;
    prod_nxt.accel_p  = '0;
    for (int i = 0; i < 3; i++) begin
      gabs = s1_r.gyro_raw[i][15] ? 16'(-s1_r.gyro_raw[i]) : s1_r.gyro_raw[i];
      prod_nxt.gyro_neg[i] = s1_r.gyro_raw[i][15];
      prod_nxt.gyro_mag[i] = ({16'd0, gabs} * {15'd0, gscale}) + GYRO_ROUND;
      prod_nxt.accel_p[i]  = 32'($signed(s1_r.accel_raw[i]) * ascale);
    end
  end

  // Stage two: scaling divides and offsets.
  always_comb begin
    logic signed [26:0] temp_adj;
    logic signed [26:0] temp_q;
    logic [60:0]        gprod;
    logic [31:0]        gq;
    temp_adj = s2_r.temp_p + (s2_r.temp_p[26] ? TEMP_BIAS : 27'sd0);
    temp_q   = (temp_adj >>> 8) + TEMP_OFFSET;
    frame_nxt.seq     = seq_r;
    frame_nxt.raw     = s2_r.raw;
    frame_nxt.temp_m  = {{5{temp_q[26]}}, temp_q};
    frame_nxt.accel_m = s2_r.accel_p;
    frame_nxt.gyro_m  = '0;
    for (int i = 0; i < 3; i++) begin
      gprod = {29'd0, s2_r.gyro_mag[i]} * {32'd0, DIV1000_RECIP};
      gq    = 32'(gprod >> DIV1000_SHIFT);
      frame_nxt.gyro_m[i] = s2_r.gyro_neg[i] ? 32'(-gq) : gq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      seq_r      <= '0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= in_smp.valid;
      end
      if (s2_take) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_valid_r && frm_ready) begin
        seq_r <= seq_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_smp.valid) begin
      s1_r <= in_sample;
    end
    if (s2_take && s1_valid_r) begin
      s2_r <= prod_nxt;
    end
  end

  issf_frame_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (s2_valid_r),
    .frm_in    (frame_nxt),
    .frm_ready (frm_ready),
    .out_frm   (out_frm)
  );

endmodule
